/* hdl/thm_pkg.sv */
// ----------------------------------------------------------------------------
// Load health monitor package
// Types, constants and controller/datapath signal groups shared by the block.
// ----------------------------------------------------------------------------
package thm_pkg;

    localparam int LOAD_W    = 16;
    localparam int ERR_W     = 8;
    localparam int RATE_W    = 14;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;
    localparam int PHASE_W   = 3;

    // The load scale 10^10 is multiplied in one bit per cycle.
    localparam int                 C_MUL_BITS = 34;
    localparam logic [C_MUL_BITS-1:0] C_LOAD_SCALE = 34'd10000000000;
    localparam int                 C_Q_BITS   = 16;
    localparam int                 C_CNT_W    = $clog2(C_MUL_BITS);

    localparam logic [LOAD_W-1:0] C_LOAD_ILL   = 16'd10000;
    localparam logic [LOAD_W-1:0] C_LOAD_RST   = 16'd100;
    localparam logic [LOAD_W-1:0] C_LOAD_SAT   = 16'hFFFF;
    localparam logic [LOAD_W-1:0] C_LIMIT_RST  = 16'd8000;
    localparam logic [ERR_W-1:0]  C_MAXERR_RST = 8'd3;
    localparam logic [ERR_W-1:0]  C_FAIL_SAT   = 8'hFF;
    localparam logic [RATE_W-1:0] C_RATE_RST   = 14'd100;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_ENABLE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_LIMIT     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERRORS     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE      = 4'd3;

    typedef enum logic [PHASE_W-1:0] {
        PH_DISABLED    = 3'd0,
        PH_NOT_STARTED = 3'd1,
        PH_PRIMED      = 3'd2,
        PH_FINE        = 3'd3,
        PH_ILL         = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_MUL,
        CS_SAT,
        CS_DIV,
        CS_DONE
    } t_ctl_state;

    typedef struct packed {
        logic in_ready;
        logic start;
        logic mul_step;
        logic sat_step;
        logic div_step;
        logic div_last;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic in_valid;
        logic need_div;
        logic sat;
        logic out_free;
    } t_dp_status;

endpackage

/* hdl/thm_if.sv */
// ----------------------------------------------------------------------------
// Load health monitor channel interfaces
// Sample, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface thm_sample_if #(
    parameter int TICK_WIDTH  = 48,
    parameter int STAMP_WIDTH = 48
);
    logic                   valid;
    logic                   ready;
    logic                   sample_ok;
    logic [TICK_WIDTH-1:0]  busy_ticks;
    logic [STAMP_WIDTH-1:0] stamp_us;

    modport source (output valid, output sample_ok, output busy_ticks, output stamp_us,
                    input ready);
    modport sink   (input valid, input sample_ok, input busy_ticks, input stamp_us,
                    output ready);
endinterface

interface thm_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  phase;
    logic [15:0] load;
    logic        over_limit;

    modport source (output valid, output phase, output load, output over_limit,
                    input ready);
    modport sink   (input valid, input phase, input load, input over_limit,
                    output ready);
endinterface

interface thm_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/thm_ctrl.sv */
// ----------------------------------------------------------------------------
// Load health monitor controller
// Sequences acceptance, serial multiply, saturation check, divide and output.
// ----------------------------------------------------------------------------
module thm_ctrl
    import thm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_ctl_state         r_state, n_state;
    logic [C_CNT_W-1:0] r_count, n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        o_cmd   = '0;
        case (r_state)
            CS_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.in_valid) begin
                    o_cmd.start = 1'b1;
                    n_count     = '0;
                    n_state     = i_status.need_div ? CS_MUL : CS_DONE;
                end
            end
            CS_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (r_count == C_CNT_W'(C_MUL_BITS - 1)) begin
                    n_count = '0;
                    n_state = CS_SAT;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            CS_SAT: begin
                o_cmd.sat_step = 1'b1;
                n_state        = i_status.sat ? CS_DONE : CS_DIV;
            end
            CS_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_count == C_CNT_W'(C_Q_BITS - 1)) begin
                    o_cmd.div_last = 1'b1;
                    n_count        = '0;
                    n_state        = CS_DONE;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            CS_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = CS_IDLE;
                end
            end
            default: begin
                n_state = CS_IDLE;
                n_count = '0;
            end
        endcase
    end

endmodule

/* hdl/thm_datapath.sv */
// ----------------------------------------------------------------------------
// Load health monitor datapath
// Configuration and phase state, shift-add multipliers, restoring divider
// and the output register.
// ----------------------------------------------------------------------------
module thm_datapath
    import thm_pkg::*;
#(
    parameter int TICK_WIDTH  = 48,
    parameter int STAMP_WIDTH = 48
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    thm_sample_if.sink   i_sample,
    thm_cfg_if.sink      i_cfg,
    thm_result_if.source o_result,
    input  t_dp_cmd      i_cmd,
    output t_dp_status   o_status
);

    localparam int NUM_W = TICK_WIDTH + C_MUL_BITS;
    localparam int DEN_W = STAMP_WIDTH + RATE_W + C_Q_BITS;
    localparam int DIV_W = (NUM_W > DEN_W) ? NUM_W : DEN_W;

    // Configuration registers
    logic              r_enable;
    logic [LOAD_W-1:0] r_load_limit;
    logic [ERR_W-1:0]  r_max_errors;
    logic [RATE_W-1:0] r_tick_rate;

    // Monitor state
    t_phase                 r_phase, n_phase;
    logic [LOAD_W-1:0]      r_load, n_load;
    logic [ERR_W-1:0]       r_fail, n_fail;
    logic [TICK_WIDTH-1:0]  r_prev_ticks, n_prev_ticks;
    logic [STAMP_WIDTH-1:0] r_prev_stamp, n_prev_stamp;

    // Arithmetic working registers
    logic [DIV_W-1:0]      r_num, n_num;
    logic [DIV_W-1:0]      r_nmc, n_nmc;
    logic [C_MUL_BITS-1:0] r_kbits, n_kbits;
    logic [DIV_W-1:0]      r_den, n_den;
    logic [DIV_W-1:0]      r_dmc, n_dmc;
    logic [RATE_W-1:0]     r_rbits, n_rbits;
    logic [C_Q_BITS-1:0]   r_quo, n_quo;

    // Output register
    logic               r_out_valid, n_out_valid;
    logic [PHASE_W-1:0] r_out_phase;
    logic [LOAD_W-1:0]  r_out_load;
    logic               r_out_over;

    t_phase                 cur_phase;
    logic                   stamp_newer;
    logic [TICK_WIDTH-1:0]  dticks;
    logic [STAMP_WIDTH-1:0] dt;
    logic [ERR_W-1:0]       fail_inc;
    logic [DIV_W-1:0]       dsh;
    logic                   fits;
    logic [C_Q_BITS-1:0]    quo_step;

    assign i_sample.ready = i_cmd.in_ready;
    assign i_cfg.ready    = 1'b1;

    assign o_result.valid      = r_out_valid;
    assign o_result.phase      = r_out_phase;
    assign o_result.load       = r_out_load;
    assign o_result.over_limit = r_out_over;

    // Once a sample is taken while disabled, the phase register holds the disabled code until reset.
    assign cur_phase   = r_enable ? r_phase : PH_DISABLED;
    assign stamp_newer = i_sample.stamp_us > r_prev_stamp;
    assign dticks      = i_sample.busy_ticks - r_prev_ticks;
    assign dt          = i_sample.stamp_us - r_prev_stamp;
    assign fail_inc    = (r_fail == C_FAIL_SAT) ? r_fail : r_fail + 1'b1;

    assign dsh      = r_den >> 1;
    assign fits     = r_num >= dsh;
    assign quo_step = {r_quo[C_Q_BITS-2:0], fits};

    assign o_status.in_valid = i_sample.valid;
    assign o_status.need_div = i_sample.sample_ok && stamp_newer &&
                               (cur_phase == PH_PRIMED || cur_phase == PH_ILL ||
                                cur_phase == PH_FINE);
    assign o_status.sat      = (r_den == '0) || (r_num >= (r_den << C_Q_BITS));
    assign o_status.out_free = !r_out_valid || o_result.ready;

    always_comb begin
        n_phase      = r_phase;
        n_load       = r_load;
        n_fail       = r_fail;
        n_prev_ticks = r_prev_ticks;
        n_prev_stamp = r_prev_stamp;
        n_num        = r_num;
        n_nmc        = r_nmc;
        n_kbits      = r_kbits;
        n_den        = r_den;
        n_dmc        = r_dmc;
        n_rbits      = r_rbits;
        n_quo        = r_quo;

        if (i_cmd.start) begin
            n_phase = cur_phase;
            n_num   = '0;
            n_nmc   = DIV_W'(dticks);
            n_kbits = C_LOAD_SCALE;
            n_den   = '0;
            n_dmc   = DIV_W'(dt);
            n_rbits = r_tick_rate;
            case (cur_phase)
                PH_NOT_STARTED: begin
                    if (i_sample.sample_ok) begin
                        n_prev_ticks = i_sample.busy_ticks;
                        n_prev_stamp = i_sample.stamp_us;
                        n_phase      = PH_PRIMED;
                    end
                end
                PH_PRIMED, PH_ILL, PH_FINE: begin
                    if (i_sample.sample_ok) begin
                        n_prev_ticks = i_sample.busy_ticks;
                        n_prev_stamp = i_sample.stamp_us;
                        n_fail       = '0;
                        n_phase      = PH_FINE;
                    end else if (cur_phase == PH_FINE) begin
                        n_fail = fail_inc;
                        if (fail_inc >= r_max_errors) begin
                            n_load  = C_LOAD_ILL;
                            n_phase = PH_ILL;
                        end
                    end
                end
                default: begin
                    n_phase = PH_DISABLED;
                end
            endcase
        end

        if (i_cmd.mul_step) begin
            if (r_kbits[0]) begin
                n_num = r_num + r_nmc;
            end
            if (r_rbits[0]) begin
                n_den = r_den + r_dmc;
            end
            n_nmc   = r_nmc << 1;
            n_dmc   = r_dmc << 1;
            n_kbits = r_kbits >> 1;
            n_rbits = r_rbits >> 1;
        end

        if (i_cmd.sat_step) begin
            if (o_status.sat) begin
                n_load = C_LOAD_SAT;
            end
            n_den = r_den << C_Q_BITS;
            n_quo = '0;
        end

        if (i_cmd.div_step) begin
            n_den = dsh;
            n_quo = quo_step;
            if (fits) begin
                n_num = r_num - dsh;
            end
            if (i_cmd.div_last) begin
                n_load = quo_step;
            end
        end

        n_out_valid = r_out_valid;
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b1;
            r_load_limit <= C_LIMIT_RST;
            r_max_errors <= C_MAXERR_RST;
            r_tick_rate  <= C_RATE_RST;
            r_phase      <= PH_NOT_STARTED;
            r_load       <= C_LOAD_RST;
            r_fail       <= '0;
            r_prev_ticks <= '0;
            r_prev_stamp <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_load       <= n_load;
            r_fail       <= n_fail;
            r_prev_ticks <= n_prev_ticks;
            r_prev_stamp <= n_prev_stamp;
            r_out_valid  <= n_out_valid;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_MONITOR_ENABLE: r_enable     <= i_cfg.data[0];
                    CFG_LOAD_LIMIT:     r_load_limit <= i_cfg.data[LOAD_W-1:0];
                    CFG_MAX_ERRORS:     r_max_errors <= i_cfg.data[ERR_W-1:0];
                    CFG_TICK_RATE:      r_tick_rate  <= i_cfg.data[RATE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_num   <= n_num;
        r_nmc   <= n_nmc;
        r_kbits <= n_kbits;
        r_den   <= n_den;
        r_dmc   <= n_dmc;
        r_rbits <= n_rbits;
        r_quo   <= n_quo;
        if (i_cmd.out_load) begin
            r_out_phase <= r_phase;
            r_out_load  <= r_load;
            r_out_over  <= r_load > r_load_limit;
        end
    end

endmodule

/* hdl/thread_load_health_monitor.sv */
// A sample that needs no load computation goes from acceptance to the output stage; a load
// computation runs 34 multiply steps, 1 range check and 16 divide steps, and skips the
// divide steps when the quotient saturates. One sample is handled at a time: a new sample
// is taken only once the previous one has reached the output register. Reset is synchronous,
// active low; it restores the configuration, the monitor state and the output valid flag,
// while the arithmetic registers are reloaded.
// ----------------------------------------------------------------------------
// Thread load health monitor
// Tracks the busy-tick counter of one execution unit and reports its phase,
// load in hundredths of a percent and an over-limit flag for every sample.
// ----------------------------------------------------------------------------
module thread_load_health_monitor
    import thm_pkg::*;
#(
    parameter int TICK_WIDTH  = 48,
    parameter int STAMP_WIDTH = 48
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    thm_sample_if.sink   i_sample,
    thm_cfg_if.sink      i_cfg,
    thm_result_if.source o_result
);

    // The controller accepts one sample transaction when idle. The datapath
    // updates the phase, failure count and baseline in that same cycle and
    // reports whether a new load has to be worked out. If it does, the
    // numerator dticks * 10^10 and the denominator dt * tick_rate are built
    // by shift-and-add, one multiplier bit per cycle, both at once. A single
    // compare step then decides saturation (zero divisor or a quotient that does
    // not fit in 16 bits); otherwise a restoring divider produces one
    // quotient bit per cycle.
    //
    // The result sits in an output register, so a new sample transaction can be
    // taken while the previous result still waits for the downstream side.
    // Configuration writes are taken in any cycle.

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    thm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    thm_datapath #(
        .TICK_WIDTH  (TICK_WIDTH),
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_sample),
        .i_cfg    (i_cfg),
        .o_result (o_result),
        .i_cmd    (w_cmd),
        .o_status (w_status)
    );

endmodule
